/* design/rolling_zscore_normalizer_macros.svh */
// assertion macros for the rolling z-score normalizer
`ifndef ROLLING_ZSCORE_NORMALIZER_MACROS_SVH
`define ROLLING_ZSCORE_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS
`define RZN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rzn assertion failed");
`define RZN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rzn assertion failed");
`else
`define RZN_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RZN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/rzn_pkg.sv */
// shared types and constants of the rolling z-score normalizer
package rzn_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TAG_W      = 32;
    localparam int SCORE_W    = 24;
    localparam int HELD_W     = 9;
    localparam int WLEN_W     = 9;
    localparam int THR_W      = 23;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;
    localparam int FRAC_SHIFT = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_THRESHOLD = 4'd1;

    localparam logic [WLEN_W-1:0]  WLEN_RESET    = 9'd256;
    localparam logic [THR_W-1:0]   THR_RESET     = 23'd1;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = 24'h7FFFFF;
    localparam logic [SCORE_W-1:0] SCORE_MIN_MAG = 24'h800000;

    typedef enum logic {OP_PUSH, OP_CLEAR} op_t;

    typedef struct packed {
        logic                       cmd;
        logic [TAG_W-1:0]           time_tag;
        logic signed [SAMPLE_W-1:0] price_sample;
        logic signed [SAMPLE_W-1:0] volume_sample;
        logic signed [SAMPLE_W-1:0] momentum_sample;
    } sample_t;

    typedef struct packed {
        logic [TAG_W-1:0]          time_out;
        logic signed [SCORE_W-1:0] price_score;
        logic signed [SCORE_W-1:0] volume_score;
        logic signed [SCORE_W-1:0] momentum_score;
        logic [HELD_W-1:0]         held_count;
    } result_t;

    typedef struct packed {
        op_t                        op;
        logic [TAG_W-1:0]           time_tag;
        logic signed [SAMPLE_W-1:0] price;
        logic signed [SAMPLE_W-1:0] volume;
        logic signed [SAMPLE_W-1:0] momentum;
    } entry_t;

    typedef struct packed {
        logic [WLEN_W-1:0] window_len;
        logic [THR_W-1:0]  flat_threshold;
        logic              clear;
    } cfg_t;

endpackage

/* design/rolling_zscore_normalizer.sv */
// top level of the three-channel rolling z-score normalizer
// Each item pushed is either a sample (three signed Q12.12 values and a time tag) or a clear
// command; every item gives exactly one result with the tag, three Q8.16 scores and the held
// count. Items wait in a two-entry input queue and are worked one at a time. A clear is
// finished in the idle state; a sample with fewer than two held ends after the update and
// multiply states; otherwise each channel's bit-serial divider runs twice (variance, then
// score) around the bit-serial square root, and the three channels run side by side.
// The ring windows sit in one memory with a registered read port. Configuration writes are
// always ready and must only be made while the block is idle; writing window_len clears the
// windows.
module rolling_zscore_normalizer
    import rzn_pkg::*;
#(
    parameter int WINDOW_MAX = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  sample_t               sample,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result
);

    cfg_t   cfg;
    entry_t entry;
    logic   avail;
    logic   take;

    rzn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .take      (take),
        .avail     (avail),
        .entry     (entry),
        .cfg       (cfg)
    );

    rzn_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .avail  (avail),
        .entry  (entry),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

/* design/rzn_front.sv */
// front end: configuration registers, item classification and a two-entry queue
module rzn_front
    import rzn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  sample_t               sample,
    input  logic                  take,
    output logic                  avail,
    output entry_t                entry,
    output cfg_t                  cfg
);

    logic [WLEN_W-1:0] window_len_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic              clear_reg;
    entry_t            q_mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              accept;
    entry_t            classified;

    assign cfg_ready = 1'b1;
    assign full      = (count_reg == 2'd2);
    assign avail     = (count_reg != 2'd0);
    assign entry     = q_mem[rd_ptr_reg];
    assign accept    = push && !full;
    assign cfg       = '{window_len: window_len_reg, flat_threshold: threshold_reg,
                         clear: clear_reg};

    always_comb
    begin
        classified.time_tag = sample.time_tag;
        classified.price    = sample.price_sample;
        classified.volume   = sample.volume_sample;
        classified.momentum = sample.momentum_sample;
        unique case (sample.cmd)
            1'b1:    classified.op = OP_CLEAR;
            default: classified.op = OP_PUSH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_RESET;
            threshold_reg  <= THR_RESET;
            clear_reg      <= 1'b0;
        end
        else
        begin
            clear_reg <= cfg_valid && cfg_ready && (cfg_index == CFG_WINDOW_LEN);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LEN:     window_len_reg <= cfg_data[WLEN_W-1:0];
                    CFG_FLAT_THRESHOLD: threshold_reg  <= cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                q_mem[wr_ptr_reg] <= classified;
                wr_ptr_reg        <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (accept && !take)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (take && !accept)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* design/rzn_div.sv */
// restoring divider, one quotient bit per cycle
module rzn_div
    import rzn_pkg::*;
#(
    parameter int DW  = 64,
    parameter int DVW = 41
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic [DW-1:0]  quotient,
    output logic           done
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   dvd_reg;
    logic [DVW-1:0]  dvs_reg;
    logic [DVW-1:0]  rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DVW:0]    rem_sh;
    logic [DVW+1:0]  diff;
    logic            ge;

    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge       = !diff[DVW+1];
    assign quotient = dvd_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNTW'(1));
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* design/rzn_sqrt.sv */
// floor square root, one root bit per cycle
module rzn_sqrt
    import rzn_pkg::*;
#(
    parameter int DW = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DW-1:0]   radicand,
    output logic [DW/2-1:0] root,
    output logic            done
);

    localparam int RW   = DW / 2;
    localparam int CNTW = $clog2(RW + 1);

    logic [DW-1:0]   val_reg;
    logic [RW-1:0]   root_reg;
    logic [RW:0]     rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+3:0]   diff;
    logic            ge;

    assign rem_sh = {rem_reg, val_reg[DW-1:DW-2]};
    assign diff   = {1'b0, rem_sh} - {2'b00, root_reg, 2'b01};
    assign ge     = !diff[RW+3];
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNTW'(1));
            if (start)
            begin
                val_reg  <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(RW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[RW:0] : rem_sh[RW:0];
                root_reg <= {root_reg[RW-2:0], ge};
                val_reg  <= {val_reg[DW-3:0], 2'b00};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* design/rzn_back.sv */
// back end: ring windows, running totals, scoring sequencer and result register
`include "rolling_zscore_normalizer_macros.svh"
module rzn_back
    import rzn_pkg::*;
#(
    parameter int WINDOW_MAX = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    avail,
    input  entry_t  entry,
    output logic    take,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int LANES = 3;
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = $clog2(WINDOW_MAX);
    localparam int TW    = SAMPLE_W + CW;
    localparam int QW    = 2 * SAMPLE_W - 2 + CW;
    localparam int DW    = CW + QW;
    localparam int RW    = DW / 2;
    localparam int DVW   = CW + RW;
    localparam int NW    = SAMPLE_W + CW + 1;
    localparam int MW    = SAMPLE_W + CW;
    localparam int PW    = 2 * SAMPLE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_MUL, S_VAR, S_VWAIT, S_SQWAIT, S_NS, S_SWAIT
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              fill_reg;
    logic [SW-1:0]              slot_reg;
    logic                       out_valid_reg;
    result_t                    result_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic signed [SAMPLE_W-1:0] x_reg [LANES];
    logic [LANES*SAMPLE_W-1:0]  ring_mem [WINDOW_MAX];
    logic [LANES*SAMPLE_W-1:0]  rd_data_reg;
    logic signed [TW-1:0]       total_reg [LANES];
    logic [QW-1:0]              sq_reg [LANES];
    logic [DW-1:0]              nq_reg [LANES];
    logic [DW-1:0]              ss_reg [LANES];
    logic signed [NW-1:0]       num_reg [LANES];
    logic [2*CW-1:0]            nn_reg;
    logic [RW-1:0]              s_reg [LANES];
    logic                       flat_reg [LANES];

    logic [CW-1:0]              win_eff;
    logic                       win_full;
    logic [CW-1:0]              slot_inc;
    logic [SW-1:0]              slot_wrap;
    logic [CW-1:0]              fill_inc;
    logic [2*CW-1:0]            nn_c;
    logic [LANES*SAMPLE_W-1:0]  wr_word;
    logic                       div_start;
    logic                       sqrt_start;
    logic [LANES-1:0]           div_done;
    logic [LANES-1:0]           sqrt_done;

    logic signed [SAMPLE_W-1:0] old_x [LANES];
    logic signed [PW-1:0]       old_sq [LANES];
    logic signed [PW-1:0]       new_sq [LANES];
    logic signed [TW-1:0]       total_upd [LANES];
    logic [QW-1:0]              sq_upd [LANES];
    logic [TW-1:0]              smag [LANES];
    logic [2*TW-1:0]            ss_full [LANES];
    logic [DW-1:0]              nq_c [LANES];
    logic signed [NW-1:0]       nx_c [LANES];
    logic [NW-1:0]              num_abs [LANES];
    logic [DW-1:0]              div_dvd [LANES];
    logic [DVW-1:0]             div_dvs [LANES];
    logic [DW-1:0]              div_q [LANES];
    logic [RW-1:0]              sqrt_root [LANES];
    logic [SCORE_W-1:0]         q_neg [LANES];
    logic [SCORE_W-1:0]         score_c [LANES];

    function automatic logic [CW-1:0] clamp_window(input logic [WLEN_W-1:0] wl);
        if (wl == '0)
        begin
            return CW'(1);
        end
        if (int'(wl) > WINDOW_MAX)
        begin
            return CW'(WINDOW_MAX);
        end
        return CW'(wl);
    endfunction

    assign win_eff    = clamp_window(cfg.window_len);
    assign win_full   = (fill_reg >= win_eff);
    assign slot_inc   = CW'(slot_reg) + CW'(1);
    assign slot_wrap  = (slot_inc == win_eff) ? '0 : slot_inc[SW-1:0];
    assign fill_inc   = win_full ? fill_reg : fill_reg + CW'(1);
    assign nn_c       = fill_reg * (fill_reg - CW'(1));
    assign wr_word    = {x_reg[2], x_reg[1], x_reg[0]};
    assign take       = (state_reg == S_IDLE) && avail && !out_valid_reg;
    assign empty      = !out_valid_reg;
    assign result     = result_reg;
    assign div_start  = (state_reg == S_VAR) || (state_reg == S_NS);
    assign sqrt_start = (state_reg == S_VWAIT) && (&div_done);

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign old_x[k]     = rd_data_reg[k*SAMPLE_W +: SAMPLE_W];
        assign old_sq[k]    = old_x[k] * old_x[k];
        assign new_sq[k]    = x_reg[k] * x_reg[k];
        assign total_upd[k] = (win_full ? total_reg[k] - TW'(old_x[k]) : total_reg[k])
                              + TW'(x_reg[k]);
        assign sq_upd[k]    = (win_full ? sq_reg[k] - QW'($unsigned(old_sq[k])) : sq_reg[k])
                              + QW'($unsigned(new_sq[k]));
        assign smag[k]      = total_reg[k][TW-1] ? TW'(-total_reg[k]) : TW'(total_reg[k]);
        assign ss_full[k]   = smag[k] * smag[k];
        assign nq_c[k]      = fill_reg * sq_reg[k];
        assign nx_c[k]      = $signed({1'b0, fill_reg}) * x_reg[k];
        assign num_abs[k]   = num_reg[k][NW-1] ? NW'(-num_reg[k]) : NW'(num_reg[k]);
        assign div_dvd[k]   = (state_reg == S_VAR) ? nq_reg[k] - ss_reg[k]
                              : DW'({num_abs[k][MW-1:0], {FRAC_SHIFT{1'b0}}});
        assign div_dvs[k]   = (state_reg == S_VAR) ? DVW'(nn_reg) : fill_reg * s_reg[k];
        assign q_neg[k]     = (div_q[k] > DW'(SCORE_MIN_MAG)) ? SCORE_MIN_MAG
                              : div_q[k][SCORE_W-1:0];

        always_comb
        begin
            if (flat_reg[k])
            begin
                score_c[k] = '0;
            end
            else if (num_reg[k][NW-1])
            begin
                score_c[k] = -q_neg[k];
            end
            else
            begin
                score_c[k] = (div_q[k] > DW'(SCORE_MAX)) ? SCORE_MAX : div_q[k][SCORE_W-1:0];
            end
        end

        rzn_div #(.DW(DW), .DVW(DVW)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dvd[k]),
            .divisor  (div_dvs[k]),
            .quotient (div_q[k]),
            .done     (div_done[k])
        );

        rzn_sqrt #(.DW(DW)) u_sqrt (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (sqrt_start),
            .radicand (div_q[k]),
            .root     (sqrt_root[k]),
            .done     (sqrt_done[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            ring_mem[slot_reg] <= wr_word;
        end
        if (take)
        begin
            rd_data_reg <= ring_mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LANES; k++)
            begin
                total_reg[k] <= '0;
                sq_reg[k]    <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.clear)
            begin
                fill_reg <= '0;
                slot_reg <= '0;
                for (int k = 0; k < LANES; k++)
                begin
                    total_reg[k] <= '0;
                    sq_reg[k]    <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        tag_reg  <= entry.time_tag;
                        x_reg[0] <= entry.price;
                        x_reg[1] <= entry.volume;
                        x_reg[2] <= entry.momentum;
                        if (entry.op == OP_CLEAR)
                        begin
                            fill_reg <= '0;
                            slot_reg <= '0;
                            for (int k = 0; k < LANES; k++)
                            begin
                                total_reg[k] <= '0;
                                sq_reg[k]    <= '0;
                            end
                            result_reg    <= '{time_out: entry.time_tag, default: '0};
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_UPD;
                        end
                    end
                end
                S_UPD:
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        total_reg[k] <= total_upd[k];
                        sq_reg[k]    <= sq_upd[k];
                    end
                    fill_reg  <= fill_inc;
                    slot_reg  <= slot_wrap;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        nq_reg[k]  <= nq_c[k];
                        ss_reg[k]  <= ss_full[k][DW-1:0];
                        num_reg[k] <= nx_c[k] - NW'(total_reg[k]);
                    end
                    nn_reg <= nn_c;
                    if (fill_reg < CW'(2))
                    begin
                        result_reg    <= '{time_out: tag_reg,
                                           held_count: HELD_W'(fill_reg),
                                           default: '0};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_VAR;
                    end
                end
                S_VAR: state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (&div_done)
                    begin
                        state_reg <= S_SQWAIT;
                    end
                end
                S_SQWAIT:
                begin
                    if (&sqrt_done)
                    begin
                        for (int k = 0; k < LANES; k++)
                        begin
                            s_reg[k] <= sqrt_root[k];
                        end
                        state_reg <= S_NS;
                    end
                end
                S_NS:
                begin
                    for (int k = 0; k < LANES; k++)
                    begin
                        flat_reg[k] <= (s_reg[k] == '0)
                                       || (s_reg[k] < RW'(cfg.flat_threshold));
                    end
                    state_reg <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (&div_done)
                    begin
                        result_reg.time_out       <= tag_reg;
                        result_reg.price_score    <= score_c[0];
                        result_reg.volume_score   <= score_c[1];
                        result_reg.momentum_score <= score_c[2];
                        result_reg.held_count     <= HELD_W'(fill_reg);
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RZN_ASSERT_NOW(a_fill_in_window, clk, rst_n, !cfg.clear, fill_reg <= win_eff)
    `RZN_ASSERT_NOW(a_slot_in_window, clk, rst_n, !cfg.clear, CW'(slot_reg) < win_eff)
    `RZN_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !pop, $stable(result_reg))
    `RZN_ASSERT_NOW(a_take_when_free, clk, rst_n, take, !out_valid_reg && (state_reg == S_IDLE))

endmodule

/* tb/rolling_zscore_normalizer_test.sv */
// self-checking testbench for the rolling z-score normalizer
`timescale 1ns / 100ps

module rolling_zscore_normalizer_test;
    import rzn_pkg::*;

    localparam int DEPTH = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 250;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    sample_t               sample = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    result_t               result;

    rolling_zscore_normalizer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push), .full(full), .sample(sample),
        .empty(empty), .pop(pop), .result(result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // window state mirrored from the block
    logic signed [SAMPLE_W-1:0] ring [3][DEPTH];
    int unsigned                write_slot, fill_level;
    longint                     chan_sum [3];
    logic [63:0]                chan_sq_sum [3];
    logic [WLEN_W-1:0]          window_len = WLEN_RESET;
    logic [THR_W-1:0]           flat_threshold = THR_RESET;

    sample_t pending_items [$];
    result_t due_results [$];
    int      items_sent, results_seen, clears_sent, scored_nonzero, mismatches, cfg_writes;
    int      burst_left, gap_left, stall_pct, stall_left, idle_cycles;

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root, bit_q;
        root = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > v)
            bit_q = bit_q >> 2;
        while (bit_q != 0)
        begin
            if (v >= root + bit_q)
            begin
                v = v - (root + bit_q);
                root = (root >> 1) + bit_q;
            end
            else
                root = root >> 1;
            bit_q = bit_q >> 2;
        end
        return root;
    endfunction

    function automatic logic [SCORE_W-1:0] channel_score(int ch, longint x, int unsigned n);
        logic [63:0] nn, smag, spread, varq, dev, mag, quot;
        longint      num;
        nn = n;
        if (n < 2)
            return '0;
        smag = chan_sum[ch] < 0 ? -chan_sum[ch] : chan_sum[ch];
        spread = nn * chan_sq_sum[ch] - smag * smag;
        varq = spread / (nn * (nn - 1));
        dev = floor_root(varq);
        if (dev == 0 || dev < flat_threshold)
            return '0;
        num = longint'(n) * x - chan_sum[ch];
        mag = (num < 0 ? -num : num);
        mag = mag << FRAC_SHIFT;
        quot = mag / (nn * dev);
        if (num < 0)
        begin
            if (quot > SCORE_MIN_MAG)
                quot = SCORE_MIN_MAG;
            return -quot[SCORE_W-1:0];
        end
        if (quot > SCORE_MAX)
            quot = SCORE_MAX;
        return quot[SCORE_W-1:0];
    endfunction

    task automatic empty_windows();
        write_slot = 0;
        fill_level = 0;
        for (int k = 0; k < 3; k++)
        begin
            chan_sum[k] = 0;
            chan_sq_sum[k] = 0;
        end
    endtask

    task automatic zscore_predict(sample_t it);
        result_t     r;
        int unsigned w, slot;
        longint      x [3];
        longint      old;
        r = '0;
        r.time_out = it.time_tag;
        if (it.cmd == OP_CLEAR)
        begin
            empty_windows();
            due_results.insert(due_results.size(), r);
            return;
        end
        w = window_len == 0 ? 1 : (window_len > DEPTH ? DEPTH : window_len);
        slot = write_slot % w;
        x[0] = it.price_sample;
        x[1] = it.volume_sample;
        x[2] = it.momentum_sample;
        for (int k = 0; k < 3; k++)
        begin
            if (fill_level >= w)
            begin
                old = ring[k][slot];
                chan_sum[k] -= old;
                chan_sq_sum[k] -= 64'(old * old);
            end
            ring[k][slot] = x[k][SAMPLE_W-1:0];
            chan_sum[k] += x[k];
            chan_sq_sum[k] += 64'(x[k] * x[k]);
        end
        write_slot = (slot + 1) % w;
        if (fill_level < w)
            fill_level++;
        r.price_score    = channel_score(0, x[0], fill_level);
        r.volume_score   = channel_score(1, x[1], fill_level);
        r.momentum_score = channel_score(2, x[2], fill_level);
        r.held_count     = fill_level[HELD_W-1:0];
        due_results.insert(due_results.size(), r);
    endtask

    function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] base, int bits);
        return base + SAMPLE_W'($urandom_range(0, (1 << bits) - 1)) - SAMPLE_W'(1 << (bits - 1));
    endfunction

    // mostly well-formed sample streams at varied spreads, a few clears
    function automatic sample_t random_item(logic [SAMPLE_W-1:0] base, int bits);
        sample_t it;
        int      mode;
        it = '0;
        it.time_tag = $urandom;
        mode = $urandom_range(0, 99);
        if (mode < 3)
            it.cmd = OP_CLEAR;
        else
            it.cmd = OP_PUSH;
        if (mode < 15)
        begin
            it.price_sample = SAMPLE_W'($urandom);
            it.volume_sample = SAMPLE_W'($urandom);
            it.momentum_sample = SAMPLE_W'($urandom);
        end
        else if (mode < 22)
        begin
            it.price_sample = base;
            it.volume_sample = base;
            it.momentum_sample = near(base, 1);
        end
        else
        begin
            it.price_sample = near(base, bits);
            it.volume_sample = near(~base, bits);
            it.momentum_sample = near(base, $urandom_range(1, 20));
        end
        return it;
    endfunction

    task automatic queue_random(int count);
        logic [SAMPLE_W-1:0] base;
        int                  bits;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                base = SAMPLE_W'($urandom);
                bits = $urandom_range(1, 16);
            end
            pending_items.insert(pending_items.size(), random_item(base, bits));
        end
    endtask

    task automatic add_item(logic cmd, logic [31:0] tag, logic [23:0] p, logic [23:0] v,
                            logic [23:0] m);
        sample_t it;
        it.cmd = cmd;
        it.time_tag = tag;
        it.price_sample = p;
        it.volume_sample = v;
        it.momentum_sample = m;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || push || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_WINDOW_LEN)
        begin
            window_len = data[WLEN_W-1:0];
            empty_windows();
        end
        else if (idx == CFG_FLAT_THRESHOLD)
            flat_threshold = data[THR_W-1:0];
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                zscore_predict(sample);
                items_sent++;
                if (sample.cmd == OP_CLEAR)
                    clears_sent++;
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    sample <= pending_items[0];
                    pending_items.delete(0);
                    push <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left--;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // receiver: stall rate is redrawn after each stretch of random length
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result tag %h", result.time_out);
                end
                else
                begin
                    result_t want;
                    want = due_results[0];
                    due_results.delete(0);
                    if (want.price_score != 0 || want.volume_score != 0
                        || want.momentum_score != 0)
                        scored_nonzero++;
                    if (result.time_out !== want.time_out
                        || result.price_score !== want.price_score
                        || result.volume_score !== want.volume_score
                        || result.momentum_score !== want.momentum_score
                        || result.held_count !== want.held_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("exp %h %h %h %h %0d / got %h %h %h %h %0d",
                                     want.time_out, want.price_score, want.volume_score,
                                     want.momentum_score, want.held_count, result.time_out,
                                     result.price_score, result.volume_score,
                                     result.momentum_score, result.held_count);
                    end
                end
            end
            if (stall_left <= 0)
            begin
                stall_left = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 70;
                    default: stall_pct = 97;
                endcase
            end
            stall_left--;
            pop <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d results pending", idle_cycles,
                     due_results.size());
            $display("** rolling_zscore_normalizer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        empty_windows();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, flat windows, clears
        add_item(OP_PUSH, 32'h0, 24'h0, 24'h0, 24'h0);
        add_item(OP_PUSH, 32'hFFFFFFFF, 24'h7FFFFF, 24'h800000, 24'h0);
        add_item(OP_PUSH, 32'h1, 24'h800000, 24'h7FFFFF, 24'h0);
        add_item(OP_PUSH, 32'h2, 24'h7FFFFF, 24'h800000, 24'h000001);
        add_item(OP_PUSH, 32'h3, 24'h800000, 24'h800000, 24'hFFFFFF);
        add_item(OP_CLEAR, 32'hA5A5A5A5, 24'h123456, 24'h654321, 24'hFFFFFF);
        add_item(OP_PUSH, 32'h4, 24'h001000, 24'h001000, 24'h001000);
        add_item(OP_PUSH, 32'h5, 24'h001000, 24'h001000, 24'h001001);
        add_item(OP_PUSH, 32'h6, 24'h001000, 24'h001002, 24'h001000);
        for (int i = 0; i < 8; i++)
            add_item(OP_PUSH, 32'h10 + 32'(i), 24'h000100, 24'hFFFF00, 24'h000100 + 24'(i));
        add_item(OP_PUSH, 32'h20, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        add_item(OP_CLEAR, 32'h5A5A5A5A, 24'h0, 24'h0, 24'h0);
        add_item(OP_CLEAR, 32'h21, 24'h0, 24'h0, 24'h0);
        add_item(OP_PUSH, 32'h22, 24'h400000, 24'hC00000, 24'h000001);
        add_item(OP_PUSH, 32'h23, 24'hC00000, 24'h400000, 24'hFFFFFF);
        queue_random(300);
        wait_idle();

        write_reg(CFG_WINDOW_LEN, 23'h7FFE01);
        write_reg(CFG_FLAT_THRESHOLD, 23'd0);
        queue_random(100);
        wait_idle();

        write_reg(CFG_WINDOW_LEN, 23'd0);
        write_reg(CFG_FLAT_THRESHOLD, 23'h7FFFFF);
        queue_random(60);
        wait_idle();

        write_reg(CFG_WINDOW_LEN, 23'd2);
        write_reg(CFG_FLAT_THRESHOLD, 23'd1);
        queue_random(150);
        wait_idle();

        write_reg(CFG_WINDOW_LEN, 23'd511);
        write_reg(CFG_FLAT_THRESHOLD, 23'd4096);
        queue_random(350);
        wait_idle();

        write_reg(CFG_WINDOW_LEN, 23'($urandom_range(3, 40)));
        write_reg(CFG_FLAT_THRESHOLD, 23'($urandom_range(0, 64)));
        queue_random(300);
        wait_idle();

        write_reg(CFG_IDX_W'(5), 23'h1FF);
        write_reg(CFG_WINDOW_LEN, 23'd256);
        write_reg(CFG_FLAT_THRESHOLD, 23'd0);
        queue_random(300);
        wait_idle();

        $display("%0d items sent (%0d clears), %0d results checked, %0d with nonzero scores",
                 items_sent, clears_sent, results_seen, scored_nonzero);
        $display("%0d register writes over seven window/threshold settings, %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("** rolling_zscore_normalizer: PASSED **");
        else
            $display("** rolling_zscore_normalizer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/rzn_pkg.sv
design/rzn_front.sv
design/rzn_div.sv
design/rzn_sqrt.sv
design/rzn_back.sv
design/rolling_zscore_normalizer.sv
tb/rolling_zscore_normalizer_test.sv
